// File: design/obl_pkg.sv
// Order book level table: shared types, codes and widths.
// Used by obl_cell, obl_side and order_book_level_table_unit.
package obl_pkg;

  localparam int PRICE_W       = 32;
  localparam int QTY_W         = 48;
  localparam int LEVELS_DEF    = 64;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_UPDATE = 2'd2
  } action_e;

  localparam logic SIDE_ASK = 1'b0;
  localparam logic SIDE_BID = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY,
    ST_RESULT
  } state_e;

  // Per-side command broadcast to every cell of the row
  typedef struct packed {
    logic apply;
    logic clear;
    logic create;
    logic remove;
    logic add;
    logic set;
  } obl_cmd_t;

endpackage

// File: design/order_book_level_table_unit.sv
// Order book level table top level: transaction control, both book sides
// and the result register. Depends on obl_pkg and obl_side.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one transaction: action,
//   side, price, qty. Output channel (out_valid_o/out_ready_i) returns one
//   result per transaction: online flag, best bid, best ask and overflow.
//   Each side is a row of LEVELS cells, best level in cell 0 (bids kept in
//   descending, asks in ascending order).
//   Sequence: an add or update passes through ST_SEARCH, where the price
//   match flag ripples one cell per cycle down the row, then ST_APPLY,
//   where all cells shift or update at once, then ST_RESULT, where the
//   result is loaded once the output register is free. Clear and the
//   unused action code skip ST_SEARCH. One transaction is worked on at a
//   time; the next is accepted in the cycle after the previous result is
//   loaded, even while that result is still stalled.
//   When the receiver stalls, the finished result waits in the output
//   register; the next result is held in ST_RESULT until it is free.
//   Reset empties both sides (level counts zero) and clears the channels;
//   no clearing pass is needed.
module order_book_level_table_unit import obl_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic               side_i,
  input  logic [PRICE_W-1:0] price_i,
  input  logic [QTY_W-1:0]   qty_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               online_o,
  output logic [PRICE_W-1:0] best_bid_price_o,
  output logic [QTY_W-1:0]   best_bid_qty_o,
  output logic [PRICE_W-1:0] best_ask_price_o,
  output logic [QTY_W-1:0]   best_ask_qty_o,
  output logic               overflow_o
);

  localparam int SCW = $clog2(LEVELS);

  state_e             state_q, state_d;
  logic [SCW-1:0]     scnt_q, scnt_d;
  action_e            op_action_q;
  logic               op_side_q;
  logic [PRICE_W-1:0] op_price_q;
  logic [QTY_W-1:0]   op_qty_q;
  logic               ovf_q, ovf_d;

  logic               out_valid_q;
  logic               online_q;
  logic [PRICE_W-1:0] bid_price_q, ask_price_q;
  logic [QTY_W-1:0]   bid_qty_q, ask_qty_q;
  logic               out_ovf_q;

  logic               in_fire, ld_result, out_free, do_apply;
  logic               found_sel, full_sel, qty_zero;
  logic               want_new, create, remove, add_hit, set_hit;
  obl_cmd_t           cmd, bid_cmd, ask_cmd;

  logic               bid_found, bid_full, bid_ne;
  logic               ask_found, ask_full, ask_ne;
  logic [PRICE_W-1:0] bid_best_price, ask_best_price;
  logic [QTY_W-1:0]   bid_best_qty, ask_best_qty;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    scnt_d  = scnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          scnt_d = '0;
          if (action_e'(action_i) == ACT_ADD || action_e'(action_i) == ACT_UPDATE) begin
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_SEARCH: begin
        scnt_d = scnt_q + SCW'(1);
        if (scnt_q == SCW'(LEVELS - 1)) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_ready_o = 1'b0;
    ld_result  = 1'b0;
    do_apply   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SEARCH: in_ready_o = 1'b0;
      ST_APPLY:  do_apply   = 1'b1;
      ST_RESULT: ld_result  = out_free;
      default:   in_ready_o = 1'b0;
    endcase
  end

  // Decision for the selected side
  assign found_sel = (op_side_q == SIDE_BID) ? bid_found : ask_found;
  assign full_sel  = (op_side_q == SIDE_BID) ? bid_full : ask_full;
  assign qty_zero  = (op_qty_q == '0);
  assign want_new  = !found_sel &&
                     (op_action_q == ACT_ADD || (op_action_q == ACT_UPDATE && !qty_zero));
  assign create    = want_new && !full_sel;
  assign remove    = found_sel && op_action_q == ACT_UPDATE && qty_zero;
  assign add_hit   = found_sel && op_action_q == ACT_ADD;
  assign set_hit   = found_sel && op_action_q == ACT_UPDATE && !qty_zero;
  assign ovf_d     = do_apply ? (want_new && full_sel) : ovf_q;

  always_comb begin
    cmd        = '0;
    cmd.apply  = do_apply;
    cmd.clear  = do_apply && op_action_q == ACT_CLEAR;
    cmd.create = create;
    cmd.remove = remove;
    cmd.add    = add_hit;
    cmd.set    = set_hit;
    bid_cmd    = (op_side_q == SIDE_BID) ? cmd : '0;
    ask_cmd    = (op_side_q == SIDE_ASK) ? cmd : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scnt_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scnt_q  <= scnt_d;
      ovf_q   <= ovf_d;
      if (ld_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_action_q <= action_e'(action_i);
      op_side_q   <= side_i;
      op_price_q  <= price_i;
      op_qty_q    <= qty_i;
    end
    if (ld_result) begin
      online_q    <= bid_ne && ask_ne;
      bid_price_q <= (bid_ne && ask_ne) ? bid_best_price : '0;
      bid_qty_q   <= (bid_ne && ask_ne) ? bid_best_qty : '0;
      ask_price_q <= (bid_ne && ask_ne) ? ask_best_price : '0;
      ask_qty_q   <= (bid_ne && ask_ne) ? ask_best_qty : '0;
      out_ovf_q   <= ovf_q;
    end
  end

  obl_side #(
    .LEVELS  (LEVELS),
    .DESCEND (1'b1)
  ) u_bid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (bid_cmd),
    .op_price_i   (op_price_q),
    .op_qty_i     (op_qty_q),
    .found_o      (bid_found),
    .full_o       (bid_full),
    .nonempty_o   (bid_ne),
    .best_price_o (bid_best_price),
    .best_qty_o   (bid_best_qty)
  );

  obl_side #(
    .LEVELS  (LEVELS),
    .DESCEND (1'b0)
  ) u_ask (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ask_cmd),
    .op_price_i   (op_price_q),
    .op_qty_i     (op_qty_q),
    .found_o      (ask_found),
    .full_o       (ask_full),
    .nonempty_o   (ask_ne),
    .best_price_o (ask_best_price),
    .best_qty_o   (ask_best_qty)
  );

  assign out_valid_o      = out_valid_q;
  assign online_o         = online_q;
  assign best_bid_price_o = bid_price_q;
  assign best_bid_qty_o   = bid_qty_q;
  assign best_ask_price_o = ask_price_q;
  assign best_ask_qty_o   = ask_qty_q;
  assign overflow_o       = out_ovf_q;

  a_no_create_and_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_apply |-> !(create && remove))
    else $error("create and remove in the same transaction");

  a_create_fills_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_apply && create) |=> ((op_side_q == SIDE_BID) ? bid_ne : ask_ne))
    else $error("side empty after level create");

  a_clear_empties_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_apply && op_action_q == ACT_CLEAR) |=>
      ((op_side_q == SIDE_BID) ? !bid_ne : !ask_ne))
    else $error("side not empty after clear");

  a_overflow_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_apply && ovf_d) |-> (full_sel && !found_sel))
    else $error("overflow without a full side");

endmodule

// File: design/obl_cell.sv
// One price level cell: holds a price and quantity, compares against the
// transaction price, ripples the match flag and shifts with its neighbors.
// Depends on obl_pkg.
module obl_cell import obl_pkg::*; #(
  parameter bit DESCEND = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  obl_cmd_t           cmd_i,
  input  logic [PRICE_W-1:0] op_price_i,
  input  logic [QTY_W-1:0]   op_qty_i,
  input  logic               occ_i,
  input  logic               left_ahead_i,
  input  logic [PRICE_W-1:0] left_price_i,
  input  logic [QTY_W-1:0]   left_qty_i,
  input  logic [PRICE_W-1:0] right_price_i,
  input  logic [QTY_W-1:0]   right_qty_i,
  input  logic               found_i,
  output logic               found_o,
  output logic               ahead_o,
  output logic [PRICE_W-1:0] price_o,
  output logic [QTY_W-1:0]   qty_o
);

  logic [PRICE_W-1:0] price_q, price_d;
  logic [QTY_W-1:0]   qty_q, qty_d;
  logic               found_q;
  logic               eq;
  logic               ahead;
  logic [QTY_W:0]     sum;
  logic [QTY_W-1:0]   sat_sum;

  assign eq      = occ_i && (price_q == op_price_i);
  assign ahead   = occ_i && (DESCEND ? (price_q > op_price_i) : (price_q < op_price_i));
  assign sum     = {1'b0, qty_q} + {1'b0, op_qty_i};
  assign sat_sum = sum[QTY_W] ? {QTY_W{1'b1}} : sum[QTY_W-1:0];

  always_comb begin
    price_d = price_q;
    qty_d   = qty_q;
    if (cmd_i.apply && !ahead) begin
      if (cmd_i.create) begin
        if (left_ahead_i) begin
          price_d = op_price_i;
          qty_d   = op_qty_i;
        end else begin
          price_d = left_price_i;
          qty_d   = left_qty_i;
        end
      end else if (cmd_i.remove) begin
        price_d = right_price_i;
        qty_d   = right_qty_i;
      end else if (eq && cmd_i.add) begin
        qty_d = sat_sum;
      end else if (eq && cmd_i.set) begin
        qty_d = op_qty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    qty_q   <= qty_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_i | eq;
    end
  end

  assign found_o = found_q;
  assign ahead_o = ahead;
  assign price_o = price_q;
  assign qty_o   = qty_q;

endmodule

// File: design/obl_side.sv
// One side of the book: a row of level cells kept in price order with the
// best level in cell 0, plus the level count. Depends on obl_pkg, obl_cell.
module obl_side import obl_pkg::*; #(
  parameter int LEVELS  = LEVELS_DEF,
  parameter bit DESCEND = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  obl_cmd_t           cmd_i,
  input  logic [PRICE_W-1:0] op_price_i,
  input  logic [QTY_W-1:0]   op_qty_i,
  output logic               found_o,
  output logic               full_o,
  output logic               nonempty_o,
  output logic [PRICE_W-1:0] best_price_o,
  output logic [QTY_W-1:0]   best_qty_o
);

  localparam int CW = $clog2(LEVELS + 1);

  logic [CW-1:0]      count_q, count_d;
  logic [PRICE_W-1:0] price [LEVELS];
  logic [QTY_W-1:0]   qty   [LEVELS];
  logic               ahead [LEVELS];
  logic               found [LEVELS];

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    logic               occ;
    logic               left_ahead;
    logic [PRICE_W-1:0] left_price, right_price;
    logic [QTY_W-1:0]   left_qty, right_qty;
    logic               found_in;

    assign occ = CW'(i) < count_q;

    if (i == 0) begin : g_first
      assign left_ahead = 1'b1;
      assign left_price = '0;
      assign left_qty   = '0;
      assign found_in   = 1'b0;
    end else begin : g_mid
      assign left_ahead = ahead[i-1];
      assign left_price = price[i-1];
      assign left_qty   = qty[i-1];
      assign found_in   = found[i-1];
    end

    if (i == LEVELS - 1) begin : g_last
      assign right_price = '0;
      assign right_qty   = '0;
    end else begin : g_inner
      assign right_price = price[i+1];
      assign right_qty   = qty[i+1];
    end

    obl_cell #(
      .DESCEND (DESCEND)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd_i),
      .op_price_i    (op_price_i),
      .op_qty_i      (op_qty_i),
      .occ_i         (occ),
      .left_ahead_i  (left_ahead),
      .left_price_i  (left_price),
      .left_qty_i    (left_qty),
      .right_price_i (right_price),
      .right_qty_i   (right_qty),
      .found_i       (found_in),
      .found_o       (found[i]),
      .ahead_o       (ahead[i]),
      .price_o       (price[i]),
      .qty_o         (qty[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.apply && cmd_i.create) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.apply && cmd_i.remove) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign found_o      = found[LEVELS-1];
  assign full_o       = (count_q == CW'(LEVELS));
  assign nonempty_o   = (count_q != '0);
  assign best_price_o = price[0];
  assign best_qty_o   = qty[0];

endmodule

// File: sim/order_book_level_table_unit_tb.sv
// Testbench for order_book_level_table_unit: directed table, random market-feed traffic;
// results checked vs. typed rows or a two-sided book predictor. Uses obl_pkg and the unit.
module order_book_level_table_unit_tb;
  import obl_pkg::*;

  localparam int DEPTH = LEVELS_DEF;
  localparam int CYCLE_LIMIT = 600_000;
  localparam int HOLD_CYCLES = 800;
  localparam logic [1:0] ACT_RSVD = 2'd3;
  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
  localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

  typedef struct packed {
    logic               online;
    logic [PRICE_W-1:0] bid_price;
    logic [QTY_W-1:0]   bid_qty;
    logic [PRICE_W-1:0] ask_price;
    logic [QTY_W-1:0]   ask_qty;
    logic               overflow;
  } book_res_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic               typed;
    book_res_t          res;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] drv_action = '0;
  logic drv_side = 1'b0;
  logic [PRICE_W-1:0] drv_price = '0;
  logic [QTY_W-1:0] drv_qty = '0;
  logic drv_typed = 1'b0;
  book_res_t drv_res = '0;
  logic out_ready = 1'b0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;

  logic in_ready_o, out_valid_o, online_o, overflow_o;
  logic [PRICE_W-1:0] best_bid_price_o, best_ask_price_o;
  logic [QTY_W-1:0] best_bid_qty_o, best_ask_qty_o;

  int snd_idle = 14;
  int rcv_idle = 75;
  int sent = 0;
  int err_cnt = 0;
  int cycles = 0;

  logic [PRICE_W-1:0] lvl_price [2][DEPTH];
  logic [QTY_W-1:0]   lvl_qty   [2][DEPTH];
  int                 lvl_cnt   [2] = '{0, 0};
  book_res_t          pending_books [$];
  stim_row_t          dir_rows [$];

  order_book_level_table_unit #(.LEVELS(DEPTH)) uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .action_i         (drv_action),
    .side_i           (drv_side),
    .price_i          (drv_price),
    .qty_i            (drv_qty),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .online_o         (online_o),
    .best_bid_price_o (best_bid_price_o),
    .best_bid_qty_o   (best_bid_qty_o),
    .best_ask_price_o (best_ask_price_o),
    .best_ask_qty_o   (best_ask_qty_o),
    .overflow_o       (overflow_o)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Book predictor: levels kept in ascending price order per side
  function automatic book_res_t book_step(logic [1:0] a, logic s, logic [PRICE_W-1:0] p,
                                          logic [QTY_W-1:0] q);
    book_res_t r;
    int n, pos, i, sd;
    logic hit;
    logic [QTY_W:0] sum;
    r = '0;
    sd = int'(s);
    n = lvl_cnt[sd];
    pos = 0;
    if (a == ACT_CLEAR) begin
      lvl_cnt[sd] = 0;
    end else if (a == ACT_ADD || a == ACT_UPDATE) begin
      while (pos < n && lvl_price[sd][pos] < p) pos++;
      hit = (pos < n) && (lvl_price[sd][pos] == p);
      if (hit) begin
        if (a == ACT_ADD) begin
          sum = {1'b0, lvl_qty[sd][pos]} + {1'b0, q};
          lvl_qty[sd][pos] = sum[QTY_W] ? QTY_MAX : sum[QTY_W-1:0];
        end else if (q == '0) begin
          for (i = pos; i + 1 < n; i++) begin
            lvl_price[sd][i] = lvl_price[sd][i+1];
            lvl_qty[sd][i] = lvl_qty[sd][i+1];
          end
          lvl_cnt[sd] = n - 1;
        end else begin
          lvl_qty[sd][pos] = q;
        end
      end else if (!(a == ACT_UPDATE && q == '0)) begin
        if (n >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          for (i = n; i > pos; i--) begin
            lvl_price[sd][i] = lvl_price[sd][i-1];
            lvl_qty[sd][i] = lvl_qty[sd][i-1];
          end
          lvl_price[sd][pos] = p;
          lvl_qty[sd][pos] = q;
          lvl_cnt[sd] = n + 1;
        end
      end
    end
    if (lvl_cnt[SIDE_BID] > 0 && lvl_cnt[SIDE_ASK] > 0) begin
      r.online = 1'b1;
      r.bid_price = lvl_price[SIDE_BID][lvl_cnt[SIDE_BID]-1];
      r.bid_qty = lvl_qty[SIDE_BID][lvl_cnt[SIDE_BID]-1];
      r.ask_price = lvl_price[SIDE_ASK][0];
      r.ask_qty = lvl_qty[SIDE_ASK][0];
    end
    return r;
  endfunction

  function automatic book_res_t mk_res(logic on, logic [PRICE_W-1:0] bp, logic [QTY_W-1:0] bq,
                                       logic [PRICE_W-1:0] ap, logic [QTY_W-1:0] aq);
    book_res_t r;
    r = '{online: on, bid_price: bp, bid_qty: bq, ask_price: ap, ask_qty: aq, overflow: 1'b0};
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] a, logic s, logic [PRICE_W-1:0] p,
                                       logic [QTY_W-1:0] q, logic typed, book_res_t r);
    stim_row_t row;
    row = '{action: a, side: s, price: p, qty: q, typed: typed, res: r};
    return row;
  endfunction

  task automatic cmp_field(string name, logic [63:0] e, logic [63:0] g);
    if (e !== g) begin
      $error("%s: expected %h, got %h", name, e, g);
      err_cnt++;
    end
  endtask

  // Transaction monitor: checks results, then records predictions for accepted items
  always @(posedge clk) begin
    book_res_t e, p;
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        if (pending_books.size() == 0) begin
          $error("result transaction with no expectation pending");
          err_cnt++;
        end else begin
          e = pending_books.pop_front();
          cmp_field("online", 64'(e.online), 64'(online_o));
          cmp_field("best_bid_price", 64'(e.bid_price), 64'(best_bid_price_o));
          cmp_field("best_bid_qty", 64'(e.bid_qty), 64'(best_bid_qty_o));
          cmp_field("best_ask_price", 64'(e.ask_price), 64'(best_ask_price_o));
          cmp_field("best_ask_qty", 64'(e.ask_qty), 64'(best_ask_qty_o));
          cmp_field("overflow", 64'(e.overflow), 64'(overflow_o));
        end
      end
      if (in_valid && in_ready_o) begin
        p = book_step(drv_action, drv_side, drv_price, drv_qty);
        pending_books.push_back(drv_typed ? drv_res : p);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(stim_row_t row);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    drv_action <= row.action;
    drv_side <= row.side;
    drv_price <= row.price;
    drv_qty <= row.qty;
    drv_typed <= row.typed;
    drv_res <= row.res;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    sent++;
  endtask

  task automatic send_op(logic [1:0] a, logic s, logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
    send_item(mk_row(a, s, p, q, 1'b0, '0));
  endtask

  task automatic drain_book;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_books.size() != 0) @(posedge clk);
  endtask

  function automatic logic [QTY_W-1:0] pick_qty();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 18) return QTY_MAX;
    if (r < 40) return QTY_W'({$urandom, $urandom});
    return QTY_W'($urandom_range(1, 5000));
  endfunction

  function automatic logic [PRICE_W-1:0] pick_price(logic s);
    int r, sd;
    r = $urandom_range(99);
    sd = int'(s);
    if (r < 45 && lvl_cnt[sd] > 0) return lvl_price[sd][$urandom_range(lvl_cnt[sd] - 1)];
    if (r < 75) return PRICE_W'(1000 + $urandom_range(0, 47));
    if (r < 93) return $urandom;
    if (r < 96) return '0;
    return PRICE_MAX;
  endfunction

  // Clear one side, then snapshot k distinct levels in scrambled order
  task automatic fill_side(logic s, int k);
    logic [PRICE_W-1:0] base;
    int step, i;
    base = $urandom_range(0, 32'h7fff_0000);
    step = $urandom_range(1, 5);
    send_op(ACT_CLEAR, s, $urandom, QTY_W'({$urandom, $urandom}));
    for (i = 0; i < k; i++) begin
      send_op(ACT_ADD, s, base + PRICE_W'(((i * 29) % k) * step), pick_qty());
    end
  endtask

  task automatic send_random;
    int r;
    logic s;
    r = $urandom_range(99);
    s = 1'($urandom_range(1));
    if (r < 5) begin
      fill_side(s, ($urandom_range(99) < 8) ? $urandom_range(64, 68) : $urandom_range(1, 10));
    end else if (r < 10) begin
      send_op(ACT_RSVD, s, $urandom, QTY_W'({$urandom, $urandom}));
    end else if (r < 14) begin
      send_op(ACT_CLEAR, s, $urandom, QTY_W'({$urandom, $urandom}));
    end else if (r < 50) begin
      send_op(ACT_ADD, s, pick_price(s), pick_qty());
    end else begin
      send_op(ACT_UPDATE, s, pick_price(s), pick_qty());
    end
  endtask

  initial begin
    dir_rows.push_back(mk_row(ACT_ADD, SIDE_BID, 32'd100, 48'd5, 1'b1, '0));
    dir_rows.push_back(mk_row(ACT_RSVD, SIDE_ASK, 32'd7, 48'd7, 1'b1, '0));
    dir_rows.push_back(mk_row(ACT_UPDATE, SIDE_ASK, 32'd300, 48'd0, 1'b1, '0));
    dir_rows.push_back(mk_row(ACT_ADD, SIDE_ASK, 32'd200, 48'd7, 1'b1,
                              mk_res(1'b1, 32'd100, 48'd5, 32'd200, 48'd7)));
    dir_rows.push_back(mk_row(ACT_ADD, SIDE_BID, 32'd100, 48'd3, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_ADD, SIDE_BID, PRICE_MAX, QTY_MAX, 1'b1,
                              mk_res(1'b1, PRICE_MAX, QTY_MAX, 32'd200, 48'd7)));
    dir_rows.push_back(mk_row(ACT_ADD, SIDE_BID, PRICE_MAX, 48'd1, 1'b1,
                              mk_res(1'b1, PRICE_MAX, QTY_MAX, 32'd200, 48'd7)));
    dir_rows.push_back(mk_row(ACT_ADD, SIDE_ASK, 32'd0, 48'd0, 1'b1,
                              mk_res(1'b1, PRICE_MAX, QTY_MAX, 32'd0, 48'd0)));
    dir_rows.push_back(mk_row(ACT_UPDATE, SIDE_ASK, 32'd0, QTY_MAX, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_UPDATE, SIDE_ASK, 32'd0, 48'd0, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_UPDATE, SIDE_ASK, 32'd150, 48'd9, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_UPDATE, SIDE_BID, PRICE_MAX, 48'd0, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_RSVD, SIDE_BID, PRICE_MAX, QTY_MAX, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_UPDATE, SIDE_BID, 32'd50, 48'd0, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_UPDATE, SIDE_BID, 32'd100, 48'hAAAA_AAAA_AAAA, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_CLEAR, SIDE_ASK, 32'h1234_5678, 48'h9, 1'b1, '0));
    dir_rows.push_back(mk_row(ACT_ADD, SIDE_ASK, 32'hAAAA_AAAA, 48'h5555_5555_5555, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_ADD, SIDE_ASK, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_CLEAR, SIDE_BID, PRICE_MAX, QTY_MAX, 1'b1, '0));
    dir_rows.push_back(mk_row(ACT_CLEAR, SIDE_BID, 32'd0, 48'd0, 1'b1, '0));
    dir_rows.push_back(mk_row(ACT_ADD, SIDE_BID, 32'd1, 48'd1, 1'b0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle = 14;
    rcv_idle = 75;
    foreach (dir_rows[i]) send_item(dir_rows[i]);
    fill_side(SIDE_BID, 66);
    while (sent < 140) send_random();
    drain_book();

    snd_idle = 75;
    rcv_idle = 14;
    fill_side(SIDE_ASK, 66);
    while (sent < 270) send_random();
    drain_book();

    snd_idle = 0;
    rcv_idle = 0;
    while (sent < 400) begin
      if (sent >= 300) hold_req <= 1'b1;
      send_random();
    end
    in_valid <= 1'b0;

    while (pending_books.size() != 0) @(posedge clk);
    repeat (2 * (DEPTH + 3)) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
